### design/partition_core_packer_assert.svh
// Assertion macros for the partition core packer.
// Used by the top level; clocked on the given clock, disabled while reset is low.
`ifndef PARTITION_CORE_PACKER_ASSERT_SVH
`define PARTITION_CORE_PACKER_ASSERT_SVH

// Same-cycle implication.
`define PCP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcp check failed");

// Next-cycle implication.
`define PCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pcp check failed");

`endif

### design/pcp_pkg.sv
// Shared types and constants for the partition core packer.
// No dependencies; imported by pcp_cell, partition_core_packer and the testbench.
package pcp_pkg;

    localparam int PCP_CORES = 4;
    localparam int LOAD_W    = 17;
    localparam int ID_W      = 8;

    localparam logic [LOAD_W:0] FULL_LOAD = 18'd65536;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    // Request token walking down the cell chain.
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [1:0]        mode;
        logic [ID_W-1:0]   task_id;
        logic [LOAD_W-1:0] task_load;
        logic              pick_valid;
        logic [LOAD_W-1:0] pick_load;
    } tok_t;

    // Broadcast from the end of the chain back to every cell.
    typedef struct packed {
        logic              clear;
        logic              add;
        logic [LOAD_W-1:0] load;
    } commit_t;

endpackage

### design/partition_core_packer.sv
// Top level of the partition core packer: input/output streams, fit mode register,
// cell chain and result register. Depends on pcp_pkg, pcp_cell and the assert header.
//
// Usage:
//   s_ channel: one request per transfer. s_tuser is kind (0 clear, 1 place);
//   s_tdata holds task_id and task_load. m_ channel returns one result per request.
//   cfg channel writes fit_mode (0 first, 1 best, 2 worst, 3 acts as first);
//   write it only while no request is in flight.
// Flow:
//   A request walks the chain of CORES cells, one cell per cycle, each cell
//   judging its own core. Once the last cell has registered it, the pick is
//   committed and the result is registered, raising m_tvalid. One request is in
//   flight at a time, so a new request is taken only after the last one has
//   been committed.
// Reset:
//   aresetn low clears all core loads, fit_mode to first-fit, and empties the
//   chain and the result register.
// Stall:
//   While m_tready is low with a result waiting, a finished request holds at
//   the end of the chain and s_tready stays low; nothing is dropped.
module partition_core_packer
    import pcp_pkg::*;
#(
    parameter int CORES = PCP_CORES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,   // fit_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [7:0] task_id, [24:8] task_load, rest zero
    input  logic        s_tuser,    // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] placed_task, [9:8] chosen_core, rest zero
    output logic        m_tuser     // schedulable
);

    `include "partition_core_packer_assert.svh"

    localparam int IDX_W = (CORES > 1) ? $clog2(CORES) : 1;

    logic [1:0]       fit_mode_reg;
    logic             busy_reg, busy_next;
    logic             m_valid_reg, m_valid_next;
    logic [ID_W-1:0]  placed_reg;
    logic [1:0]       chosen_reg;
    logic             sched_reg;

    tok_t             tok   [CORES+1];
    logic [IDX_W-1:0] idx   [CORES+1];
    logic [CORES-1:0] tok_valid;
    commit_t          commit;
    logic             accept, fire, hold;
    tok_t             tail;
    logic [IDX_W-1:0] tail_idx;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        tok[0].valid      = accept;
        tok[0].kind       = s_tuser;
        tok[0].mode       = fit_mode_reg;
        tok[0].task_id    = s_tdata[7:0];
        tok[0].task_load  = s_tdata[24:8];
        tok[0].pick_valid = 1'b0;
        tok[0].pick_load  = '0;
        idx[0]            = '0;
    end

    assign tail     = tok[CORES];
    assign tail_idx = idx[CORES];
    assign fire     = tail.valid && (!m_valid_reg || m_tready);
    assign hold     = tail.valid && !fire;

    always_comb begin
        commit.clear = fire && tail.kind == KIND_CLEAR;
        commit.add   = fire && tail.kind == KIND_PLACE && tail.pick_valid;
        commit.load  = tail.task_load;
    end

    for (genvar i = 0; i < CORES; i++) begin : g_cell
        pcp_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .hold       (hold),
            .tok_in     (tok[i]),
            .idx_in     (idx[i]),
            .commit     (commit),
            .commit_idx (tail_idx),
            .tok_out    (tok[i+1]),
            .idx_out    (idx[i+1])
        );
        assign tok_valid[i] = tok[i+1].valid;
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (fire) begin
            busy_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= FIT_FIRST;
            busy_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                fit_mode_reg <= cfg_data;
            end
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            placed_reg <= tail.task_id;
            if (commit.add) begin
                chosen_reg <= 2'(tail_idx);
                sched_reg  <= 1'b1;
            end else begin
                chosen_reg <= 2'd0;
                sched_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, chosen_reg, placed_reg};
    assign m_tuser  = sched_reg;

    // At most one request walks the chain, and busy tracks it exactly.
    `PCP_ASSERT_NOW(a_one_token, aclk, aresetn, 1'b1, $onehot0(tok_valid))
    `PCP_ASSERT_NOW(a_busy_match, aclk, aresetn, 1'b1, busy_reg == (|tok_valid))
    // A clear request never collects a pick.
    `PCP_ASSERT_NOW(a_clear_nopick, aclk, aresetn,
                    tail.valid && tail.kind == KIND_CLEAR, !tail.pick_valid)
    // A commit always leaves a result waiting.
    `PCP_ASSERT_NEXT(a_fire_out, aclk, aresetn, fire, m_tvalid)

endmodule

### design/pcp_cell.sv
// One core of the packer: holds the core load and refines the pick of a passing request.
// Depends on pcp_pkg.
module pcp_cell
    import pcp_pkg::*;
#(
    parameter int IDX_W = 2,
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             hold,
    input  tok_t             tok_in,
    input  logic [IDX_W-1:0] idx_in,
    input  commit_t          commit,
    input  logic [IDX_W-1:0] commit_idx,
    output tok_t             tok_out,
    output logic [IDX_W-1:0] idx_out
);

    logic [LOAD_W-1:0] load_reg, load_next;
    tok_t              tok_reg, tok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              fits, better, take;

    always_comb begin
        fits = ({1'b0, load_reg} + {1'b0, tok_in.task_load}) <= FULL_LOAD;
        better = !tok_in.pick_valid
              || (tok_in.mode == FIT_BEST  && load_reg > tok_in.pick_load)
              || (tok_in.mode == FIT_WORST && load_reg < tok_in.pick_load);
        take = tok_in.valid && tok_in.kind == KIND_PLACE && fits && better;

        tok_next = tok_in;
        idx_next = idx_in;
        if (take) begin
            tok_next.pick_valid = 1'b1;
            tok_next.pick_load  = load_reg;
            idx_next            = IDX_W'(INDEX);
        end

        load_next = load_reg;
        if (commit.clear) begin
            load_next = '0;
        end else if (commit.add && commit_idx == IDX_W'(INDEX)) begin
            load_next = load_reg + commit.load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= '0;
            tok_reg  <= '0;
            idx_reg  <= '0;
        end else begin
            load_reg <= load_next;
            // Advance the request unless the chain end is stalled.
            if (!hold) begin
                tok_reg <= tok_next;
                idx_reg <= idx_next;
            end
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

### tb/tb_partition_core_packer.sv
// Self-checking bench for partition_core_packer: directed and random task placement
// under all fit modes, with random stalls on both streams. Depends on pcp_pkg.
module tb_partition_core_packer;
    import pcp_pkg::*;

    localparam logic [1:0] FIT_SPARE   = 2'd3;  // unused code, acts as first-fit
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         PHASE_ITEMS = 265;
    localparam int         HOLD_CYCLES = 400;

    typedef struct packed {
        logic [ID_W-1:0] placed_task;
        logic [1:0]      chosen_core;
        logic            schedulable;
    } placement_t;

    typedef struct {
        bit                is_cfg;
        logic [1:0]        mode;
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [LOAD_W-1:0] load;
        bit                typed;
        logic [1:0]        core;
        logic              sched;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [7:0] task_id, [24:8] task_load, rest zero
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] placed_task, [9:8] chosen_core, rest zero
    logic        m_tuser;   // schedulable

    logic [LOAD_W-1:0] core_load_model [PCP_CORES];
    logic [1:0]        fit_mode_model;
    placement_t        pending_placements [$];
    stim_row_t         directed_rows [$];
    int                errors;
    int                cycle_count;
    bit                steady;
    int                hold_request;
    int                hold_left;

    partition_core_packer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Place one task on the core model and return the placement it earns.
    function automatic placement_t place_task(logic kind, logic [ID_W-1:0] id,
                                              logic [LOAD_W-1:0] load);
        placement_t       res;
        int               pick;
        bit               done;
        logic [LOAD_W:0]  sum;
        res.placed_task = id;
        res.chosen_core = 2'd0;
        res.schedulable = 1'b0;
        pick = -1;
        done = 0;
        if (kind == KIND_CLEAR) begin
            for (int c = 0; c < PCP_CORES; c++) core_load_model[c] = '0;
            return res;
        end
        for (int c = 0; c < PCP_CORES; c++) begin
            sum = {1'b0, core_load_model[c]} + load;
            if (sum <= FULL_LOAD && !done) begin
                if (pick < 0) begin
                    pick = c;
                    if (fit_mode_model != FIT_BEST && fit_mode_model != FIT_WORST) done = 1;
                end else if (fit_mode_model == FIT_BEST) begin
                    if (core_load_model[c] > core_load_model[pick]) pick = c;
                end else if (fit_mode_model == FIT_WORST) begin
                    if (core_load_model[c] < core_load_model[pick]) pick = c;
                end
            end
        end
        if (pick >= 0) begin
            sum = {1'b0, core_load_model[pick]} + load;
            core_load_model[pick] = sum[LOAD_W-1:0];
            res.chosen_core = pick[1:0];
            res.schedulable = 1'b1;
        end
        return res;
    endfunction

    function automatic stim_row_t make_row(bit is_cfg, logic [1:0] mode, logic kind,
                                           logic [ID_W-1:0] id, logic [LOAD_W-1:0] load,
                                           bit typed, logic [1:0] core, logic sched);
        stim_row_t r;
        r.is_cfg = is_cfg;
        r.mode   = mode;
        r.kind   = kind;
        r.id     = id;
        r.load   = load;
        r.typed  = typed;
        r.core   = core;
        r.sched  = sched;
        return r;
    endfunction

    // Bias loads toward the fit boundary so cores fill, overflow and tie.
    function automatic logic [LOAD_W-1:0] pick_task_load();
        int               roll;
        int               c;
        logic [LOAD_W:0]  room;
        roll = $urandom_range(99);
        c    = $urandom_range(PCP_CORES - 1);
        room = FULL_LOAD - core_load_model[c];
        if (roll < 40) return LOAD_W'($urandom_range(1, 24576));
        if (roll < 60) return LOAD_W'($urandom_range(0, 65536));
        if (roll < 72) return room[LOAD_W-1:0] + LOAD_W'($urandom_range(1));
        if (roll < 78) return '0;
        if (roll < 84) return LOAD_W'($urandom_range(65537, 131071));
        if (roll < 90) return 17'h10000;
        return LOAD_W'($urandom_range(131071));
    endfunction

    // Offer one request and hold it until accepted; valid stays high on return
    // unless a gap follows.
    task automatic send_request(logic kind, logic [ID_W-1:0] id, logic [LOAD_W-1:0] load,
                                bit typed, logic [1:0] core, logic sched);
        placement_t want;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, load, id};
        do @(posedge aclk); while (!s_tready);
        want = place_task(kind, id, load);
        if (typed) begin
            want.chosen_core = core;
            want.schedulable = sched;
        end
        pending_placements.push_back(want);
        if (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_placements.size() != 0);
    endtask

    task automatic set_fit_mode(logic [1:0] mode);
        drain_results();
        repeat (PCP_CORES + 2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fit_mode_model = mode;
    endtask

    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin : check_results
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_placements.size() == 0) begin
                $error("result with no request pending, m_tdata %h m_tuser %b",
                       m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_placements.pop_front();
                if (m_tdata[7:0] !== want.placed_task) begin
                    $error("placed_task expected %0d, got %0d", want.placed_task,
                           m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[9:8] !== want.chosen_core) begin
                    $error("chosen_core expected %0d, got %0d", want.chosen_core,
                           m_tdata[9:8]);
                    errors++;
                end
                if (m_tuser !== want.schedulable) begin
                    $error("schedulable expected %0d, got %0d", want.schedulable, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [1:0] phase_modes [6];
        stim_row_t  row;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        errors       = 0;
        steady       = 0;
        hold_request = 0;
        hold_left    = 0;
        fit_mode_model = FIT_FIRST;
        for (int c = 0; c < PCP_CORES; c++) core_load_model[c] = '0;

        // First-fit from reset: extremes, full cores, overload, zero load.
        directed_rows.push_back(make_row(0, 0, KIND_CLEAR, 8'hFF, 17'h1FFFF, 1, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h00, 17'h10000, 1, 0, 1));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h01, 17'h10001, 1, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h02, 17'h1FFFF, 1, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h03, 17'h00000, 1, 0, 1));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h04, 17'h10000, 1, 1, 1));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h05, 17'h10000, 1, 2, 1));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h06, 17'h10000, 1, 3, 1));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h07, 17'h00001, 1, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_CLEAR, 8'h80, 17'h00000, 1, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h55, 17'h08000, 1, 0, 1));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'hAA, 17'h08000, 1, 0, 1));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h0F, 17'h08001, 1, 1, 1));
        // Best-fit, worst-fit and the spare mode, checked by the core model.
        directed_rows.push_back(make_row(1, FIT_BEST, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_CLEAR, 8'h10, 17'h00000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h11, 17'h04000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h12, 17'h02000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h13, 17'h0C000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h14, 17'h01000, 0, 0, 0));
        directed_rows.push_back(make_row(1, FIT_WORST, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_CLEAR, 8'h20, 17'h00000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h21, 17'h04000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h22, 17'h01000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h23, 17'h03000, 0, 0, 0));
        directed_rows.push_back(make_row(1, FIT_SPARE, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h31, 17'h0F000, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, KIND_PLACE, 8'h32, 17'h02000, 0, 0, 0));

        phase_modes = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_SPARE, FIT_BEST, FIT_FIRST};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg)
                set_fit_mode(row.mode);
            else
                send_request(row.kind, row.id, row.load, row.typed, row.core, row.sched);
        end

        for (int p = 0; p < 6; p++) begin
            set_fit_mode(phase_modes[p]);
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Stall the result side long enough to back up the input.
                if (p == 1 && n == 60) hold_request = 1;
                if (p == 4 && n == 130) drain_results();
                if ($urandom_range(99) < 4)
                    send_request(KIND_CLEAR, ID_W'($urandom_range(255)),
                                 LOAD_W'($urandom_range(131071)), 0, 0, 0);
                else
                    send_request(KIND_PLACE, ID_W'($urandom_range(255)), pick_task_load(),
                                 0, 0, 0);
            end
        end
        steady = 0;

        drain_results();
        repeat (PCP_CORES + 4) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
